[hw/rtl/vci_pkg.sv]
// shared types, constants and helpers of the verlet constrain and integrate block
package vci_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_BOUNCE  = 3'd1,
    REG_GRAVITY = 3'd2,
    REG_STEP_SQ = 3'd3,
    REG_KEEP    = 3'd4,
    REG_HALF_W  = 3'd5,
    REG_HALF_H  = 3'd6,
    REG_CRADIUS = 3'd7
  } vci_reg_e;

  // container modes
  localparam logic MODE_CIRCLE = 1'b0;
  localparam logic MODE_BOX    = 1'b1;

  // register reset values
  localparam logic        RST_MODE    = 1'b1;
  localparam logic        RST_BOUNCE  = 1'b1;
  localparam logic [31:0] RST_GRAVITY = 32'd327680;
  localparam logic [31:0] RST_STEP_SQ = 32'd1193046;
  localparam logic [16:0] RST_KEEP    = 17'd64881;
  localparam logic [30:0] RST_HALF_W  = 31'd62259200;
  localparam logic [30:0] RST_HALF_H  = 31'd32768000;
  localparam logic [30:0] RST_CRADIUS = 31'd29491200;

  // fixed point scales of the bounce math
  localparam int UNIT_BITS = 28;
  localparam int KEEP_BITS = 16;

  // pipelined divider geometry
  localparam int DIV_DW = 63;
  localparam int DIV_VW = 32;
  localparam int DIV_QW = 32;

  // square root steps, one result bit per stage
  localparam int SQRT_N = 32;

  // front stages, before the square root
  typedef struct packed {
    logic               last;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic        [23:0] rad;
    logic signed [32:0] ax;
    logic signed [32:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic               bc;
    logic        [30:0] m;
    logic        [31:0] xmag;
    logic        [31:0] ymag;
    logic               sx;
    logic               sy;
    logic        [61:0] mm;
    logic        [63:0] xx;
    logic        [63:0] yy;
    logic        [62:0] xm;
    logic        [62:0] ym;
    logic signed [49:0] axh;
    logic signed [49:0] axl;
    logic signed [49:0] ayh;
    logic signed [49:0] ayl;
  } vci_front_t;

  // side data carried through the square root and the dividers
  typedef struct packed {
    logic               last;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic               bc;
    logic               fire;
    logic               sx;
    logic               sy;
    logic        [31:0] xmag;
    logic        [31:0] ymag;
    logic        [62:0] xm;
    logic        [62:0] ym;
    logic signed [33:0] accx;
    logic signed [33:0] accy;
  } vci_side_t;

  // back stages, bounce and verlet step
  typedef struct packed {
    logic               last;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic               bc;
    logic               fire;
    logic signed [33:0] accx;
    logic signed [33:0] accy;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [29:0] ux;
    logic signed [29:0] uy;
    logic signed [32:0] vx;
    logic signed [32:0] vy;
    logic signed [62:0] dpx;
    logic signed [62:0] dpy;
    logic signed [35:0] d;
    logic signed [65:0] uxd;
    logic signed [65:0] uyd;
    logic signed [39:0] rx;
    logic signed [39:0] ry;
    logic signed [57:0] rkx;
    logic signed [57:0] rky;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fpx;
    logic signed [31:0] fpy;
    logic               fc;
    logic signed [35:0] vnx;
    logic signed [35:0] vny;
  } vci_back_t;

  // clamp to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    logic signed [43:0] hi;
    logic signed [43:0] lo;
    hi = 44'sd2147483647;
    lo = -44'sd2147483648;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

[hw/rtl/vci_div.sv]
// pipelined restoring divider, one quotient bit per stage
module vci_div #(
  parameter int DW = vci_pkg::DIV_DW,
  parameter int VW = vci_pkg::DIV_VW,
  parameter int QW = vci_pkg::DIV_QW
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic [QW-1:0] quotient_o
);

  localparam int W = VW + QW;

  logic [W-1:0]  rem_q [QW];
  logic [VW-1:0] dvs_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [W-1:0]  rem_in [QW];
  logic [VW-1:0] dvs_in [QW];
  logic [QW-1:0] quo_in [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [W-1:0] shifted;
    logic         take;

    // stage inputs
    if (k == 0) begin : g_first
      assign rem_in[k] = W'(dividend_i);
      assign dvs_in[k] = divisor_i;
      assign quo_in[k] = '0;
    end else begin : g_next
      assign rem_in[k] = rem_q[k-1];
      assign dvs_in[k] = dvs_q[k-1];
      assign quo_in[k] = quo_q[k-1];
    end

    // trial subtract of the shifted divisor
    assign shifted = W'(dvs_in[k]) << B;
    assign take    = rem_in[k] >= shifted;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? (rem_in[k] - shifted) : rem_in[k];
        dvs_q[k] <= dvs_in[k];
        quo_q[k] <= quo_in[k] | (QW'(take) << B);
      end
    end
  end

  assign quotient_o = quo_q[QW-1];

endmodule

[hw/rtl/verlet_constrain_integrate.sv]
// Verlet particle step with box or circle container constraint. One particle
// enters per clock unless the output stalls; most stages belong to the 32-stage
// square root and the 32-stage dividers that scale the position onto the circle
// and form the unit normal. The pipeline moves as one: while a result waits at
// the output with m_axis_tready low, every stage holds and s_axis_tready is low.
// The user keeps configuration static while items are in flight; not enforced.
module verlet_constrain_integrate (
  input  logic         clk_i,
  input  logic         rst_ni,
  // fields from bit 0: pos_x, pos_y, prev_x, prev_y, radius, accel_x, accel_y
  input  logic [215:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // fields from bit 0: new_x, new_y, new_prev_x, new_prev_y
  output logic [127:0] m_axis_tdata,
  // fields from bit 0: was_constrained
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  import vci_pkg::*;

  localparam int NSTG = 4 + SQRT_N + DIV_QW + 9;

  // configuration registers
  logic        mode_q;
  logic        bounce_q;
  logic [31:0] grav_q;
  logic [31:0] dt2_q;
  logic [16:0] keep_q;
  logic [30:0] half_w_q;
  logic [30:0] half_h_q;
  logic [30:0] crad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= RST_MODE;
      bounce_q <= RST_BOUNCE;
      grav_q   <= RST_GRAVITY;
      dt2_q    <= RST_STEP_SQ;
      keep_q   <= RST_KEEP;
      half_w_q <= RST_HALF_W;
      half_h_q <= RST_HALF_H;
      crad_q   <= RST_CRADIUS;
    end else if (cfg_we_i) begin
      case (vci_reg_e'(cfg_idx_i))
        REG_MODE:    mode_q   <= cfg_data_i[0];
        REG_BOUNCE:  bounce_q <= cfg_data_i[0];
        REG_GRAVITY: grav_q   <= cfg_data_i;
        REG_STEP_SQ: dt2_q    <= cfg_data_i;
        REG_KEEP:    keep_q   <= cfg_data_i[16:0];
        REG_HALF_W:  half_w_q <= cfg_data_i[30:0];
        REG_HALF_H:  half_h_q <= cfg_data_i[30:0];
        REG_CRADIUS: crad_q   <= cfg_data_i[30:0];
        default:     mode_q   <= mode_q;
      endcase
    end
  end

  // whole pipeline advances together
  logic            en;
  logic [NSTG-1:0] vld_q;

  assign en            = !vld_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  vci_front_t s1_d, s1_q, s2_d, s2_q, s3_d, s3_q;
  logic [63:0]        s4_dist_q;
  logic               s4_fire_q;
  logic signed [33:0] s4_accx_q;
  logic signed [33:0] s4_accy_q;
  vci_front_t         s4_q;

  // unpack the input item
  always_comb begin
    s1_d      = '0;
    s1_d.last = s_axis_tlast;
    s1_d.x    = s_axis_tdata[31:0];
    s1_d.y    = s_axis_tdata[63:32];
    s1_d.px   = s_axis_tdata[95:64];
    s1_d.py   = s_axis_tdata[127:96];
    s1_d.rad  = s_axis_tdata[151:128];
    s1_d.ax   = {s_axis_tdata[183], s_axis_tdata[183:152]};
    s1_d.ay   = {s_axis_tdata[215], s_axis_tdata[215:184]};
  end

  // box clamp, shrunk radius, magnitudes, gravity
  always_comb begin
    logic signed [33:0] r34;
    logic signed [33:0] hh34;
    logic signed [33:0] hw34;
    logic signed [33:0] ty;
    logic signed [33:0] tx;
    logic               c;
    logic signed [32:0] mdiff;
    r34   = $signed({10'b0, s1_q.rad});
    hh34  = $signed({3'b0, half_h_q});
    hw34  = $signed({3'b0, half_w_q});
    ty    = {{2{s1_q.y[31]}}, s1_q.y};
    tx    = {{2{s1_q.x[31]}}, s1_q.x};
    c     = 1'b0;
    mdiff = $signed({2'b0, crad_q}) - $signed({9'b0, s1_q.rad});
    s2_d  = s1_q;
    if (ty - r34 < -hh34) begin
      ty = r34 - hh34;
      c  = 1'b1;
    end
    if (ty + r34 > hh34) begin
      ty = hh34 - r34;
      c  = 1'b1;
    end
    if (tx - r34 < -hw34) begin
      tx = r34 - hw34;
      c  = 1'b1;
    end
    if (tx + r34 > hw34) begin
      tx = hw34 - r34;
      c  = 1'b1;
    end
    s2_d.bx   = tx[31:0];
    s2_d.by   = ty[31:0];
    s2_d.bc   = c;
    s2_d.m    = mdiff[32] ? '0 : mdiff[30:0];
    s2_d.sx   = s1_q.x[31];
    s2_d.sy   = s1_q.y[31];
    s2_d.xmag = s1_q.x[31] ? (~s1_q.x + 32'd1) : s1_q.x;
    s2_d.ymag = s1_q.y[31] ? (~s1_q.y + 32'd1) : s1_q.y;
    s2_d.ay   = s1_q.ay + $signed({grav_q[31], grav_q});
  end

  // squares, scaled products, acceleration partial products
  always_comb begin
    s3_d     = s2_q;
    s3_d.xx  = 64'(s2_q.xmag) * 64'(s2_q.xmag);
    s3_d.yy  = 64'(s2_q.ymag) * 64'(s2_q.ymag);
    s3_d.mm  = 62'(s2_q.m) * 62'(s2_q.m);
    s3_d.xm  = 63'(s2_q.xmag) * 63'(s2_q.m);
    s3_d.ym  = 63'(s2_q.ymag) * 63'(s2_q.m);
    s3_d.axh = 50'(s2_q.ax) * 50'($signed({1'b0, dt2_q[31:16]}));
    s3_d.axl = 50'(s2_q.ax) * 50'($signed({1'b0, dt2_q[15:0]}));
    s3_d.ayh = 50'(s2_q.ay) * 50'($signed({1'b0, dt2_q[31:16]}));
    s3_d.ayl = 50'(s2_q.ay) * 50'($signed({1'b0, dt2_q[15:0]}));
  end

  // front stage registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q      <= s1_d;
      s2_q      <= s2_d;
      s3_q      <= s3_d;
      s4_q      <= s3_q;
      s4_dist_q <= s3_q.xx + s3_q.yy;
      s4_fire_q <= (s3_q.xx + s3_q.yy) > {2'b0, s3_q.mm};
      s4_accx_q <= 34'((s3_q.axh + (s3_q.axl >>> 16)) >>> 16);
      s4_accy_q <= 34'((s3_q.ayh + (s3_q.ayl >>> 16)) >>> 16);
    end
  end

  // side data into the square root
  vci_side_t side_in;

  always_comb begin
    side_in.last = s4_q.last;
    side_in.x    = s4_q.x;
    side_in.y    = s4_q.y;
    side_in.px   = s4_q.px;
    side_in.py   = s4_q.py;
    side_in.bx   = s4_q.bx;
    side_in.by   = s4_q.by;
    side_in.bc   = s4_q.bc;
    side_in.fire = s4_fire_q;
    side_in.sx   = s4_q.sx;
    side_in.sy   = s4_q.sy;
    side_in.xmag = s4_q.xmag;
    side_in.ymag = s4_q.ymag;
    side_in.xm   = s4_q.xm;
    side_in.ym   = s4_q.ym;
    side_in.accx = s4_accx_q;
    side_in.accy = s4_accy_q;
  end

  // square root, one root bit per stage
  logic [63:0] sq_rem_q  [SQRT_N];
  logic [31:0] sq_root_q [SQRT_N];
  vci_side_t   sq_side_q [SQRT_N];
  logic [63:0] sq_rem_in  [SQRT_N];
  logic [31:0] sq_root_in [SQRT_N];
  vci_side_t   sq_side_in [SQRT_N];

  for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
    localparam int B = SQRT_N - 1 - k;
    logic [65:0] trial;
    logic        take;

    if (k == 0) begin : g_first
      assign sq_rem_in[k]  = s4_dist_q;
      assign sq_root_in[k] = '0;
      assign sq_side_in[k] = side_in;
    end else begin : g_next
      assign sq_rem_in[k]  = sq_rem_q[k-1];
      assign sq_root_in[k] = sq_root_q[k-1];
      assign sq_side_in[k] = sq_side_q[k-1];
    end

    // rem holds value minus root squared
    assign trial = (66'(sq_root_in[k]) << (B + 1)) + (66'd1 << (2 * B));
    assign take  = {2'b0, sq_rem_in[k]} >= trial;

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[k]  <= take ? (sq_rem_in[k] - trial[63:0]) : sq_rem_in[k];
        sq_root_q[k] <= sq_root_in[k] | (32'(take) << B);
        sq_side_q[k] <= sq_side_in[k];
      end
    end
  end

  // scale onto the circle and form the unit normal
  vci_side_t   sq_last;
  logic [31:0] len;
  logic [31:0] q_nx, q_ny, q_ux, q_uy;

  assign sq_last = sq_side_q[SQRT_N-1];
  assign len     = sq_root_q[SQRT_N-1];

  vci_div u_div_nx (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (sq_last.xm),
    .divisor_i  (len),
    .quotient_o (q_nx)
  );

  vci_div u_div_ny (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (sq_last.ym),
    .divisor_i  (len),
    .quotient_o (q_ny)
  );

  vci_div u_div_ux (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({3'b0, sq_last.xmag, {UNIT_BITS{1'b0}}}),
    .divisor_i  (len),
    .quotient_o (q_ux)
  );

  vci_div u_div_uy (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({3'b0, sq_last.ymag, {UNIT_BITS{1'b0}}}),
    .divisor_i  (len),
    .quotient_o (q_uy)
  );

  // side data delay matching the dividers
  vci_side_t dv_side_q [DIV_QW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_side_q[0] <= sq_last;
      for (int i = 1; i < DIV_QW; i++) begin
        dv_side_q[i] <= dv_side_q[i-1];
      end
    end
  end

  vci_side_t dv_last;
  assign dv_last = dv_side_q[DIV_QW-1];

  vci_back_t b1_d, b1_q, b2_d, b2_q, b3_d, b3_q, b4_d, b4_q;
  vci_back_t b5_d, b5_q, b6_d, b6_q, b7_d, b7_q, b8_d, b8_q;

  // signed quotients and velocity
  always_comb begin
    b1_d      = '0;
    b1_d.last = dv_last.last;
    b1_d.x    = dv_last.x;
    b1_d.y    = dv_last.y;
    b1_d.px   = dv_last.px;
    b1_d.py   = dv_last.py;
    b1_d.bx   = dv_last.bx;
    b1_d.by   = dv_last.by;
    b1_d.bc   = dv_last.bc;
    b1_d.fire = dv_last.fire;
    b1_d.accx = dv_last.accx;
    b1_d.accy = dv_last.accy;
    b1_d.nx   = dv_last.sx ? -$signed(q_nx) : $signed(q_nx);
    b1_d.ny   = dv_last.sy ? -$signed(q_ny) : $signed(q_ny);
    b1_d.ux   = dv_last.sx ? -$signed(q_ux[29:0]) : $signed(q_ux[29:0]);
    b1_d.uy   = dv_last.sy ? -$signed(q_uy[29:0]) : $signed(q_uy[29:0]);
    b1_d.vx   = {dv_last.x[31], dv_last.x} - {dv_last.px[31], dv_last.px};
    b1_d.vy   = {dv_last.y[31], dv_last.y} - {dv_last.py[31], dv_last.py};
  end

  // dot product terms
  always_comb begin
    b2_d     = b1_q;
    b2_d.dpx = 63'(b1_q.vx) * 63'(b1_q.ux);
    b2_d.dpy = 63'(b1_q.vy) * 63'(b1_q.uy);
  end

  // normal velocity component
  always_comb begin
    logic signed [63:0] dsum;
    dsum   = 64'(b2_q.dpx) + 64'(b2_q.dpy);
    b3_d   = b2_q;
    b3_d.d = dsum[63:UNIT_BITS];
  end

  // normal times component
  always_comb begin
    b4_d     = b3_q;
    b4_d.uxd = 66'(b3_q.ux) * 66'(b3_q.d);
    b4_d.uyd = 66'(b3_q.uy) * 66'(b3_q.d);
  end

  // reflected velocity
  always_comb begin
    logic signed [39:0] tx;
    logic signed [39:0] ty;
    tx      = 40'($signed(b4_q.uxd[65:UNIT_BITS]));
    ty      = 40'($signed(b4_q.uyd[65:UNIT_BITS]));
    b5_d    = b4_q;
    b5_d.rx = 40'(b4_q.vx) - (tx <<< 1);
    b5_d.ry = 40'(b4_q.vy) - (ty <<< 1);
  end

  // wall loss
  always_comb begin
    b6_d     = b5_q;
    b6_d.rkx = 58'(b5_q.rx) * 58'($signed({1'b0, keep_q}));
    b6_d.rky = 58'(b5_q.ry) * 58'($signed({1'b0, keep_q}));
  end

  // pick the constrained position and previous position
  always_comb begin
    logic signed [43:0] bpx;
    logic signed [43:0] bpy;
    bpx  = 44'(b6_q.nx) - 44'($signed(b6_q.rkx[57:KEEP_BITS]));
    bpy  = 44'(b6_q.ny) - 44'($signed(b6_q.rky[57:KEEP_BITS]));
    b7_d = b6_q;
    if (mode_q == MODE_BOX) begin
      b7_d.fx  = b6_q.bx;
      b7_d.fy  = b6_q.by;
      b7_d.fpx = b6_q.px;
      b7_d.fpy = b6_q.py;
      b7_d.fc  = b6_q.bc;
    end else if (b6_q.fire) begin
      b7_d.fx  = b6_q.nx;
      b7_d.fy  = b6_q.ny;
      b7_d.fpx = bounce_q ? sat32(bpx) : b6_q.px;
      b7_d.fpy = bounce_q ? sat32(bpy) : b6_q.py;
      b7_d.fc  = 1'b1;
    end else begin
      b7_d.fx  = b6_q.x;
      b7_d.fy  = b6_q.y;
      b7_d.fpx = b6_q.px;
      b7_d.fpy = b6_q.py;
      b7_d.fc  = 1'b0;
    end
  end

  // verlet step
  always_comb begin
    b8_d     = b7_q;
    b8_d.vnx = (36'(b7_q.fx) <<< 1) - 36'(b7_q.fpx) + 36'(b7_q.accx);
    b8_d.vny = (36'(b7_q.fy) <<< 1) - 36'(b7_q.fpy) + 36'(b7_q.accy);
  end

  // back stage registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_q <= b1_d;
      b2_q <= b2_d;
      b3_q <= b3_d;
      b4_q <= b4_d;
      b5_q <= b5_d;
      b6_q <= b6_d;
      b7_q <= b7_d;
      b8_q <= b8_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= {b8_q.fy, b8_q.fx, sat32(44'(b8_q.vny)), sat32(44'(b8_q.vnx))};
      m_axis_tuser <= b8_q.fc;
      m_axis_tlast <= b8_q.last;
    end
  end

endmodule
